FILE: rtl/sfr_pkg.sv
package sfr_pkg;

	// Frame geometry
	localparam int FRAME_BYTES = 25;
	localparam int CHANNELS    = 16;
	localparam int CH_BITS     = 11;
	localparam int DATA_BITS   = CHANNELS * CH_BITS;
	localparam int FLAG_BYTE   = 23;
	localparam int COUNT_W     = 5;
	localparam int CH_IDX_W    = 4;

	localparam logic [7:0] START_MARK = 8'h0F;
	localparam logic [7:0] END_MARK   = 8'h00;

	localparam logic [COUNT_W-1:0] COUNT_FULL     = COUNT_W'(FRAME_BYTES);
	localparam logic [COUNT_W-1:0] COUNT_OVERLONG = COUNT_W'(FRAME_BYTES + 1);

	// Channel scaling: (raw - 172) * 1000 / 1639, truncated toward zero.
	// Division by 1639 is a multiply by ceil(2^32 / 1639); for products
	// below 2^21 the quotient is exact.
	localparam logic signed [11:0] RAW_OFFSET  = 12'sd172;
	localparam logic [9:0]         SCALE_NUM   = 10'd1000;
	localparam logic [21:0]        RECIP       = 22'd2620481;
	localparam int                 RECIP_SHIFT = 32;

	// Configuration defaults and register indexes
	localparam logic [15:0] MAX_GAP_RESET = 16'd150;
	localparam logic [15:0] TIMEOUT_RESET = 16'd250;
	localparam logic        REG_MAX_GAP   = 1'b0;
	localparam logic        REG_TIMEOUT   = 1'b1;

	// Input action codes
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef enum logic [1:0] {
		LINK_IDLE     = 2'd0,
		LINK_RUNNING  = 2'd1,
		LINK_FAILSAFE = 2'd2
	} link_status_t;

	typedef enum logic {
		KIND_CHANNEL  = 1'b0,
		KIND_FAILSAFE = 1'b1
	} result_kind_t;

	typedef struct packed {
		logic        we;
		logic        index;
		logic [15:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic        action;
		logic [7:0]  data_byte;
		logic [15:0] gap_us;
	} item_t;

	typedef struct packed {
		logic                kind;
		logic [3:0]          channel_index;
		logic signed [11:0]  channel_value;
		logic                digital_a;
		logic                digital_b;
		logic                frame_lost;
		logic                failsafe_bit;
		logic [1:0]          link_status;
		logic                last;
	} result_t;

	// Work handed from the front end to the channel engine
	typedef struct packed {
		result_kind_t         kind;
		logic [DATA_BITS-1:0] data;
		logic [3:0]           flags;
		link_status_t         status;
	} sfr_entry_t;

endpackage

FILE: rtl/sfr_stream_if.sv
interface sfr_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

FILE: rtl/sfr_front.sv
module sfr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  sfr_pkg::cfg_wr_t cfg,
	sfr_stream_if.sink      items,
	sfr_stream_if.source    entries
);

	logic [7:0]                  burst_q [sfr_pkg::FRAME_BYTES];
	logic [sfr_pkg::COUNT_W-1:0] count_q;
	logic [15:0]                 elapsed_q;
	sfr_pkg::link_status_t       status_q;
	logic [15:0]                 max_gap_q;
	logic [15:0]                 timeout_q;

	logic                        accept;
	logic                        is_tick;
	logic [15:0]                 elapsed_inc;
	logic                        fs_trip;
	logic                        new_burst;
	logic                        frame_ok;
	logic                        do_frame;
	logic                        good_frame;
	logic [3:0]                  flags;
	logic [sfr_pkg::COUNT_W-1:0] wr_idx;
	logic                        wr_en;
	sfr_pkg::sfr_entry_t         entry;

	// Classify the item against the current burst and link state
	always_comb begin
		accept      = items.valid && items.ready;
		is_tick     = (items.payload.action == sfr_pkg::ACT_TICK);
		elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
		fs_trip     = (status_q == sfr_pkg::LINK_RUNNING) && (elapsed_inc > timeout_q);
		new_burst   = items.payload.gap_us > max_gap_q;
		frame_ok    = (count_q == sfr_pkg::COUNT_FULL)
			&& (burst_q[0] == sfr_pkg::START_MARK)
			&& (burst_q[sfr_pkg::FRAME_BYTES-1] == sfr_pkg::END_MARK);
		do_frame    = !is_tick && new_burst && frame_ok;
		flags       = burst_q[sfr_pkg::FLAG_BYTE][3:0];
		good_frame  = !flags[3];
		wr_idx      = new_burst ? '0 : count_q;
		wr_en       = accept && !is_tick && (wr_idx < sfr_pkg::COUNT_FULL);
	end

	// Queue entry: channel bits are bytes 1..22 as one little-endian word
	always_comb begin
		entry = '0;
		if (is_tick) begin
			entry.kind   = sfr_pkg::KIND_FAILSAFE;
			entry.status = sfr_pkg::LINK_FAILSAFE;
		end else begin
			entry.kind   = sfr_pkg::KIND_CHANNEL;
			entry.flags  = flags;
			entry.status = good_frame ? sfr_pkg::LINK_RUNNING : status_q;
			for (int i = 0; i < sfr_pkg::DATA_BITS / 8; i++) begin
				entry.data[i*8 +: 8] = burst_q[i+1];
			end
		end
	end

	assign items.ready     = entries.ready;
	assign entries.valid   = items.valid && (is_tick ? fs_trip : do_frame);
	assign entries.payload = entry;

	// Burst byte store, written in arrival order
	always_ff @(posedge clk) begin
		for (int i = 0; i < sfr_pkg::FRAME_BYTES; i++) begin
			if (wr_en && (wr_idx == sfr_pkg::COUNT_W'(i))) begin
				burst_q[i] <= items.payload.data_byte;
			end
		end
	end

	// Burst count, link status, timeout counter and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			elapsed_q <= '0;
			status_q  <= sfr_pkg::LINK_IDLE;
			max_gap_q <= sfr_pkg::MAX_GAP_RESET;
			timeout_q <= sfr_pkg::TIMEOUT_RESET;
		end else begin
			if (cfg.we) begin
				case (cfg.index)
					sfr_pkg::REG_MAX_GAP: max_gap_q <= cfg.data;
					sfr_pkg::REG_TIMEOUT: timeout_q <= cfg.data;
					default: ;
				endcase
			end
			if (accept) begin
				if (is_tick) begin
					elapsed_q <= elapsed_inc;
					if (fs_trip) begin
						status_q <= sfr_pkg::LINK_FAILSAFE;
					end
				end else begin
					if (do_frame && good_frame) begin
						elapsed_q <= '0;
						status_q  <= sfr_pkg::LINK_RUNNING;
					end
					// overlong bursts park at one past a full frame
					count_q <= (wr_idx < sfr_pkg::COUNT_FULL) ? wr_idx + 1'b1
						: sfr_pkg::COUNT_OVERLONG;
				end
			end
		end
	end

endmodule

FILE: rtl/sfr_queue.sv
module sfr_queue #(
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	sfr_stream_if.sink   wr,
	sfr_stream_if.source rd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sfr_pkg::sfr_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                push;
	logic                pop;

	assign wr.ready   = (count_q != CNT_W'(DEPTH));
	assign rd.valid   = (count_q != '0);
	assign rd.payload = mem_q[rd_ptr_q];
	assign push       = wr.valid && wr.ready;
	assign pop        = rd.valid && rd.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.payload;
		end
	end

	// Pointers wrap at DEPTH; count tracks occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

FILE: rtl/sfr_back.sv
module sfr_back (
	input  logic         clk,
	input  logic         arst_n,
	sfr_stream_if.sink   entries,
	sfr_stream_if.source results
);

	typedef struct packed {
		logic       kind;
		logic [3:0] ch;
		logic [3:0] flags;
		logic [1:0] status;
		logic       last;
	} meta_t;

	logic [sfr_pkg::CH_IDX_W-1:0] ch_q;
	logic                         adv;
	logic                         issue;
	logic                         entry_last;
	logic [10:0]                  chans [sfr_pkg::CHANNELS];
	logic [10:0]                  raw;
	logic signed [11:0]           diff;
	logic [10:0]                  mag_abs;
	logic [20:0]                  mag;
	logic                         neg;
	meta_t                        meta;
	logic [42:0]                  prod;

	logic                         v_s1, v_s2, v_s3;
	logic [20:0]                  mag_s1;
	logic                         neg_s1, neg_s2;
	meta_t                        meta_s1, meta_s2, meta_s3;
	logic [10:0]                  quo_s2;
	logic signed [11:0]           value_s3;

	// Whole pipeline advances together unless the output is held
	assign adv        = !v_s3 || results.ready;
	assign issue      = adv && entries.valid;
	assign entry_last = (entries.payload.kind == sfr_pkg::KIND_FAILSAFE)
		|| (ch_q == sfr_pkg::CH_IDX_W'(sfr_pkg::CHANNELS - 1));
	assign entries.ready = adv && entry_last;

	// Channel select, offset removal, scaling by 1000 and the s2 reciprocal product
	always_comb begin
		for (int i = 0; i < sfr_pkg::CHANNELS; i++) begin
			chans[i] = entries.payload.data[i*sfr_pkg::CH_BITS +: sfr_pkg::CH_BITS];
		end
		raw     = chans[ch_q];
		diff    = $signed({1'b0, raw}) - sfr_pkg::RAW_OFFSET;
		mag_abs = diff[11] ? 11'(-diff) : diff[10:0];
		if (entries.payload.kind == sfr_pkg::KIND_FAILSAFE) begin
			mag = '0;
			neg = 1'b0;
		end else begin
			mag = 21'(mag_abs) * 21'(sfr_pkg::SCALE_NUM);
			neg = diff[11];
		end
		meta.kind   = entries.payload.kind;
		meta.ch     = (entries.payload.kind == sfr_pkg::KIND_FAILSAFE) ? '0 : ch_q;
		meta.flags  = entries.payload.flags;
		meta.status = entries.payload.status;
		meta.last   = entry_last;
		prod        = 43'(mag_s1) * 43'(sfr_pkg::RECIP);
	end

	// Channel counter within the head entry and stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			if (issue) begin
				ch_q <= entry_last ? '0 : ch_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// s1: scaled magnitude, s2: reciprocal multiply, s3: sign and output
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1   <= mag;
			neg_s1   <= neg;
			meta_s1  <= meta;
			quo_s2   <= prod[sfr_pkg::RECIP_SHIFT +: 11];
			neg_s2   <= neg_s1;
			meta_s2  <= meta_s1;
			value_s3 <= neg_s2 ? -$signed({1'b0, quo_s2}) : $signed({1'b0, quo_s2});
			meta_s3  <= meta_s2;
		end
	end

	assign results.valid                 = v_s3;
	assign results.payload.kind          = meta_s3.kind;
	assign results.payload.channel_index = meta_s3.ch;
	assign results.payload.channel_value = value_s3;
	assign results.payload.digital_a     = meta_s3.flags[0];
	assign results.payload.digital_b     = meta_s3.flags[1];
	assign results.payload.frame_lost    = meta_s3.flags[2];
	assign results.payload.failsafe_bit  = meta_s3.flags[3];
	assign results.payload.link_status   = meta_s3.status;
	assign results.payload.last          = meta_s3.last;

endmodule

FILE: rtl/sbus_frame_receiver.sv
// An item's first result passes the entry queue and the s1, s2 and s3 registers.
// Throughput: one input item per cycle while the entry queue has room; the channel
// engine emits one result per cycle unless the output is held, 16 per decoded frame.
// Reset (arst_n, async, active low): burst count, timeout counter, link status (idle),
// queue and pipeline cleared; max_gap_us = 150, failsafe_timeout_ms = 250.
module sbus_frame_receiver #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        write_en,
	input  logic        reg_index,
	input  logic [15:0] write_data,
	sfr_stream_if.sink   items,
	sfr_stream_if.source results
);

	sfr_pkg::cfg_wr_t cfg;

	sfr_stream_if #(.payload_t(sfr_pkg::sfr_entry_t)) fq ();
	sfr_stream_if #(.payload_t(sfr_pkg::sfr_entry_t)) qb ();

	assign cfg.we    = write_en;
	assign cfg.index = reg_index;
	assign cfg.data  = write_data;

	sfr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.items   (items),
		.entries (fq)
	);

	sfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fq),
		.rd     (qb)
	);

	sfr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.entries (qb),
		.results (results)
	);

	// Results of one frame leave back to back with rising channel index
	a_frame_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.ready && !results.payload.last |=> results.valid)
		else $error("frame results not contiguous");

	a_frame_order: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.ready && !results.payload.last
		|=> results.payload.channel_index == $past(results.payload.channel_index) + 4'd1)
		else $error("channel index out of order");

	// A queue entry only comes from an accepted item of the matching action
	a_entry_source: assert property (@(posedge clk) disable iff (!arst_n)
		fq.valid && fq.ready |-> items.valid && items.ready
		&& ((fq.payload.kind == sfr_pkg::KIND_FAILSAFE)
		== (items.payload.action == sfr_pkg::ACT_TICK)))
		else $error("queue entry without matching item");

endmodule

FILE: bench/tb_sbus_frame_receiver.sv
module tb_sbus_frame_receiver;

	// Channel scaling terms: (raw - ZERO_RAW) * FULL_SCALE / SPAN_RAW
	localparam int ZERO_RAW   = 172;
	localparam int FULL_SCALE = 1000;
	localparam int SPAN_RAW   = 1639;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        write_en;
	logic        reg_index;
	logic [15:0] write_data;

	sfr_stream_if #(.payload_t(sfr_pkg::item_t))   item_ch ();
	sfr_stream_if #(.payload_t(sfr_pkg::result_t)) result_ch ();

	sbus_frame_receiver dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data),
		.items      (item_ch),
		.results    (result_ch)
	);

	// Stimulus and expectation stores
	sfr_pkg::item_t   serial_items[$];
	sfr_pkg::result_t due_results[$];
	int      queued_items = 0;
	int      results_seen = 0;
	int      errors = 0;
	int      idle_pct = 27;
	bit      item_taken;
	bit      want_hold;
	int      hold_left = 0;
	logic [7:0] tx_frame[sfr_pkg::FRAME_BYTES];

	// Receiver-side copy of the block state and registers
	logic [7:0]   burst_mem[sfr_pkg::FRAME_BYTES];
	int           burst_len = 0;
	logic [15:0]  ms_since_good = '0;
	sfr_pkg::link_status_t link = sfr_pkg::LINK_IDLE;
	logic [15:0]  gap_limit = sfr_pkg::MAX_GAP_RESET;
	logic [15:0]  fs_timeout = sfr_pkg::TIMEOUT_RESET;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
				results_seen, name, got, want));
	endtask

	// Decode a closed 25-byte burst into its channel results
	function automatic void decode_frame();
		sfr_pkg::result_t r;
		logic [7:0] fl;
		logic [23:0] w;
		int         bitpos;
		int         idx;
		int         raw;
		int         scaled;
		if (burst_mem[0] == sfr_pkg::START_MARK
				&& burst_mem[sfr_pkg::FRAME_BYTES-1] == sfr_pkg::END_MARK) begin
			fl = burst_mem[sfr_pkg::FLAG_BYTE];
			if (!fl[3]) begin
				ms_since_good = '0;
				link = sfr_pkg::LINK_RUNNING;
			end
			for (int c = 0; c < sfr_pkg::CHANNELS; c++) begin
				bitpos = sfr_pkg::CH_BITS * c;
				idx = 1 + bitpos / 8;
				w = {burst_mem[idx+2], burst_mem[idx+1], burst_mem[idx]};
				raw = int'((w >> (bitpos % 8)) & 24'h7FF);
				scaled = (raw - ZERO_RAW) * FULL_SCALE / SPAN_RAW;
				r.kind          = sfr_pkg::KIND_CHANNEL;
				r.channel_index = 4'(c);
				r.channel_value = scaled[11:0];
				r.digital_a     = fl[0];
				r.digital_b     = fl[1];
				r.frame_lost    = fl[2];
				r.failsafe_bit  = fl[3];
				r.link_status   = link;
				r.last          = (c == sfr_pkg::CHANNELS - 1);
				due_results.push_back(r);
			end
		end
	endfunction

	// Advance the expected state by one accepted item
	function automatic void track_item(input sfr_pkg::item_t it);
		sfr_pkg::result_t r;
		if (it.action == sfr_pkg::ACT_TICK) begin
			if (ms_since_good != 16'hFFFF)
				ms_since_good++;
			if (link == sfr_pkg::LINK_RUNNING && ms_since_good > fs_timeout) begin
				link = sfr_pkg::LINK_FAILSAFE;
				r = '0;
				r.kind = sfr_pkg::KIND_FAILSAFE;
				r.link_status = sfr_pkg::LINK_FAILSAFE;
				r.last = 1'b1;
				due_results.push_back(r);
			end
		end else begin
			if (it.gap_us > gap_limit) begin
				if (burst_len == sfr_pkg::FRAME_BYTES)
					decode_frame();
				burst_len = 0;
			end
			if (burst_len < sfr_pkg::FRAME_BYTES) begin
				burst_mem[burst_len] = it.data_byte;
				burst_len++;
			end else begin
				burst_len = sfr_pkg::FRAME_BYTES + 1;
			end
		end
	endfunction

	// Item queueing helpers
	function automatic void queue_byte(input logic [7:0] d, input logic [15:0] g);
		serial_items.push_back(sfr_pkg::item_t'{action: sfr_pkg::ACT_BYTE,
			data_byte: d, gap_us: g});
		queued_items++;
	endfunction

	// ignored fields of a tick are left random
	function automatic void queue_tick();
		serial_items.push_back(sfr_pkg::item_t'{action: sfr_pkg::ACT_TICK,
			data_byte: 8'($urandom), gap_us: 16'($urandom)});
		queued_items++;
	endfunction

	function automatic logic [15:0] break_gap();
		if (gap_limit == 16'hFFFF)
			return 16'hFFFF;
		if ($urandom_range(3) == 0)
			return gap_limit + 16'd1;
		return 16'($urandom_range(16'hFFFF, gap_limit + 1));
	endfunction

	function automatic logic [15:0] inner_gap();
		if ($urandom_range(3) == 0)
			return gap_limit;
		return 16'($urandom_range(gap_limit, 0));
	endfunction

	function automatic logic [sfr_pkg::DATA_BITS-1:0] random_channels();
		logic [sfr_pkg::DATA_BITS-1:0] v;
		logic [10:0] raw;
		for (int c = 0; c < sfr_pkg::CHANNELS; c++) begin
			case ($urandom_range(9))
				0: raw = 11'd0;
				1: raw = 11'h7FF;
				2: raw = 11'($urandom_range(ZERO_RAW + 2, ZERO_RAW - 2));
				default: raw = 11'($urandom);
			endcase
			v[sfr_pkg::CH_BITS*c +: sfr_pkg::CH_BITS] = raw;
		end
		return v;
	endfunction

	function automatic void build_frame(input logic [sfr_pkg::DATA_BITS-1:0] chans,
			input logic [7:0] flags);
		tx_frame[0] = sfr_pkg::START_MARK;
		for (int k = 1; k < sfr_pkg::FLAG_BYTE; k++)
			tx_frame[k] = chans[8*(k-1) +: 8];
		tx_frame[sfr_pkg::FLAG_BYTE] = flags;
		tx_frame[sfr_pkg::FRAME_BYTES-1] = sfr_pkg::END_MARK;
	endfunction

	// Send n bytes of tx_frame as one burst; bytes past the frame are random.
	// Ticks are occasionally interleaved with the bytes.
	function automatic void send_burst(input int n);
		for (int k = 0; k < n; k++) begin
			if (k > 0 && $urandom_range(19) == 0)
				queue_tick();
			queue_byte(k < sfr_pkg::FRAME_BYTES ? tx_frame[k] : 8'($urandom),
				k == 0 ? break_gap() : inner_gap());
		end
	endfunction

	// One random sequence: a well-formed frame half the time, else broken ones, ticks, noise
	function automatic void queue_sequence();
		int         pick;
		int         run;
		logic [7:0] flags;
		pick = $urandom_range(99);
		run = (fs_timeout > 40) ? 40 : fs_timeout + 3;
		flags = 8'($urandom);
		flags[3] = ($urandom_range(3) == 0);
		build_frame(random_channels(), flags);
		if (pick < 50) begin
			send_burst(sfr_pkg::FRAME_BYTES);
		end else if (pick < 58) begin
			tx_frame[0] ^= 8'($urandom_range(255, 1));
			send_burst(sfr_pkg::FRAME_BYTES);
		end else if (pick < 66) begin
			tx_frame[sfr_pkg::FRAME_BYTES-1] ^= 8'($urandom_range(255, 1));
			send_burst(sfr_pkg::FRAME_BYTES);
		end else if (pick < 72) begin
			send_burst($urandom_range(sfr_pkg::FRAME_BYTES - 1, 1));
		end else if (pick < 78) begin
			send_burst(sfr_pkg::FRAME_BYTES + $urandom_range(6, 1));
		end else if (pick < 90) begin
			repeat ($urandom_range(run, 1)) queue_tick();
		end else begin
			repeat ($urandom_range(3, 1)) queue_byte(8'($urandom), 16'($urandom));
		end
	endfunction

	function automatic void queue_random_traffic(input int count);
		int target;
		target = queued_items + count;
		while (queued_items < target)
			queue_sequence();
	endfunction

	// Wait until every item is in and every expected result is out, then let the
	// pipeline empty of items that cause no result
	task automatic settle();
		while (serial_items.size() != 0 || item_ch.valid || due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [15:0] val);
		settle();
		@(negedge clk);
		write_en   <= 1'b1;
		reg_index  <= idx;
		write_data <= val;
		if (idx == sfr_pkg::REG_MAX_GAP)
			gap_limit = val;
		else
			fs_timeout = val;
		@(negedge clk);
		write_en <= 1'b0;
	endtask

	// Item driver: new transfer offered at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_taken) begin
			if (serial_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				item_ch.payload <= serial_items.pop_front();
				item_ch.valid   <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Result sink: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (want_hold) begin
			want_hold = 1'b0;
			hold_left = HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Monitor: check results against expectations, predict from accepted items
	always @(posedge clk) begin
		sfr_pkg::result_t want;
		if (result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected",
					results_seen));
			end else begin
				want = due_results.pop_front();
				check_field("kind", result_ch.payload.kind, want.kind);
				check_field("channel_index", result_ch.payload.channel_index,
					want.channel_index);
				check_field("channel_value", result_ch.payload.channel_value,
					want.channel_value);
				check_field("digital_a", result_ch.payload.digital_a, want.digital_a);
				check_field("digital_b", result_ch.payload.digital_b, want.digital_b);
				check_field("frame_lost", result_ch.payload.frame_lost, want.frame_lost);
				check_field("failsafe_bit", result_ch.payload.failsafe_bit,
					want.failsafe_bit);
				check_field("link_status", result_ch.payload.link_status,
					want.link_status);
				check_field("last", result_ch.payload.last, want.last);
			end
		end
		item_taken = item_ch.valid && item_ch.ready;
		if (item_taken)
			track_item(item_ch.payload);
	end

	initial begin
		logic [sfr_pkg::DATA_BITS-1:0] chans;
		arst_n          = 1'b0;
		write_en        = 1'b0;
		reg_index       = sfr_pkg::REG_MAX_GAP;
		write_data      = '0;
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		result_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: ticks on an idle link, then a frame of corner channel values
		queue_tick();
		queue_tick();
		chans = {11'd2047, 11'd0, 11'd170, 11'd174, 11'd1810, 11'd682, 11'd1365,
			11'd1024, 11'd2046, 11'd1, 11'd1811, 11'd173, 11'd172, 11'd171,
			11'd2047, 11'd0};
		build_frame(chans, 8'h07);
		send_burst(sfr_pkg::FRAME_BYTES);
		queue_byte(8'($urandom), gap_limit + 16'd1);

		// Short timeout: failsafe after two quiet ticks
		set_reg(sfr_pkg::REG_MAX_GAP, 16'd200);
		set_reg(sfr_pkg::REG_TIMEOUT, 16'd1);
		queue_random_traffic(90);

		// Gap threshold of one, no idling on either side
		set_reg(sfr_pkg::REG_MAX_GAP, 16'd1);
		set_reg(sfr_pkg::REG_TIMEOUT, 16'($urandom_range(12, 3)));
		settle();
		idle_pct = 0;
		queue_random_traffic(90);
		settle();
		idle_pct = 27;

		// Largest timeout: a running link stays up through a run of ticks
		set_reg(sfr_pkg::REG_MAX_GAP, 16'd400);
		set_reg(sfr_pkg::REG_TIMEOUT, 16'hFFFF);
		build_frame(random_channels(), 8'($urandom) & ~8'h08);
		send_burst(sfr_pkg::FRAME_BYTES);
		queue_byte(8'($urandom), break_gap());
		repeat (20) queue_tick();

		// Largest gap threshold: no byte can start a burst
		set_reg(sfr_pkg::REG_MAX_GAP, 16'hFFFF);
		build_frame(random_channels(), 8'h00);
		send_burst(sfr_pkg::FRAME_BYTES + 15);

		// Mid-range settings with a long result stall while frames keep coming
		set_reg(sfr_pkg::REG_MAX_GAP, 16'($urandom_range(3000, 100)));
		set_reg(sfr_pkg::REG_TIMEOUT, 16'($urandom_range(30, 5)));
		settle();
		want_hold = 1'b1;
		repeat (5) begin
			build_frame(random_channels(), 8'($urandom) & ~8'h08);
			send_burst(sfr_pkg::FRAME_BYTES);
		end
		queue_random_traffic(25);
		queue_byte(8'($urandom), break_gap());
		settle();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
